[rtl/e2q_pkg.sv]
// package: payload types, cordic constants and sequencer states for the euler to quaternion core
package e2q_pkg;

    localparam int FRAC_BITS    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 5;
    localparam int CW           = 34;  // cordic datapath width (q30 plus headroom)

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_PROD,
        ST_SUM,
        ST_DOT,
        ST_OUT
    } t_state;

    function automatic logic signed [CW-1:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic signed [CW-1:0] v;
        unique case (idx)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            5'd24: v = 34'sd63;
            5'd25: v = 34'sd31;
            5'd26: v = 34'sd15;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/e2q_cordic.sv]
// shared cordic rotator: one micro-rotation per cycle, sine and cosine of one half angle
module e2q_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [e2q_pkg::CW-1:0]     i_angle,
    output logic                              o_done,
    output logic signed [e2q_pkg::CW-1:0]     o_sin,
    output logic signed [e2q_pkg::CW-1:0]     o_cos
);
    logic signed [e2q_pkg::CW-1:0] r_x, r_y, r_z, n_x, n_y, n_z, w_fold;
    logic                          r_neg, n_neg, r_busy, n_busy, w_fneg;
    logic [e2q_pkg::STEP_W-1:0]    r_step, n_step;

    always_comb begin
        w_fold = i_angle;
        w_fneg = 1'b0;
        if (i_angle > e2q_pkg::HALF_PI_Q30) begin
            w_fold = i_angle - e2q_pkg::PI_Q30;
            w_fneg = 1'b1;
        end else if (i_angle < -e2q_pkg::HALF_PI_Q30) begin
            w_fold = i_angle + e2q_pkg::PI_Q30;
            w_fneg = 1'b1;
        end
    end

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z; n_neg = r_neg;
        n_busy = r_busy; n_step = r_step;
        if (i_start) begin
            n_x = e2q_pkg::CORDIC_GAIN; n_y = '0; n_z = w_fold; n_neg = w_fneg;
            n_busy = 1'b1; n_step = '0;
        end else if (r_busy) begin
            if (!r_z[e2q_pkg::CW-1]) begin
                n_x = r_x - (r_y >>> r_step);
                n_y = r_y + (r_x >>> r_step);
                n_z = r_z - e2q_pkg::atan_lut(r_step);
            end else begin
                n_x = r_x + (r_y >>> r_step);
                n_y = r_y - (r_x >>> r_step);
                n_z = r_z + e2q_pkg::atan_lut(r_step);
            end
            n_step = r_step + 1'b1;
            if (r_step == e2q_pkg::STEP_W'(e2q_pkg::CORDIC_STEPS - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_neg <= n_neg;
    end

    assign o_done = r_busy && (r_step == e2q_pkg::STEP_W'(e2q_pkg::CORDIC_STEPS - 1));
    // results valid the cycle after o_done
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step < e2q_pkg::STEP_W'(e2q_pkg::CORDIC_STEPS))
        else $error("cordic step out of range");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !i_start |=> !r_busy)
        else $error("cordic busy after last step");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && r_step == '0)
        else $error("cordic did not start");
endmodule

[rtl/euler_to_quaternion_continuous_core.sv]
// top level: zyx euler angles to sign-continuous unit quaternion
// order of work: for each of the three angles a cordic start, 30 micro-rotations and a capture,
// then 16 product steps, 4 sum steps, 4 dot steps and 1 load of the output word
// a new word is taken only after the result is taken, and the output waits while i_ready is low;
// a single shared cordic and one shared 34x34 multiplier do the products, a 16x16 one the dot
// o_ready is low from acceptance until the result word is taken
// reset (synchronous, active low) sets the stored quaternion to identity and idles
module euler_to_quaternion_continuous_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  e2q_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output e2q_pkg::t_out_word o_data
);
    localparam int CW = e2q_pkg::CW;
    localparam int SH = e2q_pkg::FRAC_BITS - 14;
    localparam logic signed [CW-1:0] ONE_Q = 34'sd16384;

    e2q_pkg::t_state r_state, n_state;

    // captured angles, then sin/cos: index 0 yaw, 1 pitch, 2 roll
    logic signed [CW-1:0] r_ang [3];
    logic signed [CW-1:0] r_sn [3];
    logic signed [CW-1:0] r_cs [3];
    logic [1:0]           r_ai, n_ai;
    logic                 r_cwait, n_cwait;
    // cordic result appears the cycle after its done pulse
    logic                 r_clatch;

    // eight triple products, two multiplies each
    logic signed [CW-1:0] r_prod [8];
    logic [3:0]           r_pi, n_pi;
    logic signed [CW-1:0] r_tmp;
    logic signed [15:0]   r_q [4];
    logic signed [15:0]   r_prev [4];
    logic signed [36:0]   r_dot;
    logic [1:0]           r_qi, n_qi;
    e2q_pkg::t_out_word   r_out;
    logic                 r_ov, n_ov;

    logic                 w_cstart, w_cdone;
    logic signed [CW-1:0] w_sin, w_cos, w_cang;

    e2q_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (w_cang),
        .o_done  (w_cdone),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // product k uses factors (a,b,c); sequence matches w,x,y,z terms
    // 0: cr cp cy  1: sr sp sy  2: sr cp cy  3: cr sp sy
    // 4: cr sp cy  5: sr cp sy  6: cr cp sy  7: sr sp cy
    logic signed [CW-1:0] w_fa, w_fb, w_fc, w_ma, w_mb;
    logic signed [2*CW-1:0] w_mul;
    always_comb begin
        w_fa = r_cs[2]; w_fb = r_cs[1]; w_fc = r_cs[0];
        unique case (r_pi[3:1])
            3'd0: begin w_fa = r_cs[2]; w_fb = r_cs[1]; w_fc = r_cs[0]; end
            3'd1: begin w_fa = r_sn[2]; w_fb = r_sn[1]; w_fc = r_sn[0]; end
            3'd2: begin w_fa = r_sn[2]; w_fb = r_cs[1]; w_fc = r_cs[0]; end
            3'd3: begin w_fa = r_cs[2]; w_fb = r_sn[1]; w_fc = r_sn[0]; end
            3'd4: begin w_fa = r_cs[2]; w_fb = r_sn[1]; w_fc = r_cs[0]; end
            3'd5: begin w_fa = r_sn[2]; w_fb = r_cs[1]; w_fc = r_sn[0]; end
            3'd6: begin w_fa = r_cs[2]; w_fb = r_cs[1]; w_fc = r_sn[0]; end
            default: begin w_fa = r_sn[2]; w_fb = r_sn[1]; w_fc = r_cs[0]; end
        endcase
        w_ma  = r_pi[0] ? r_tmp : w_fa;
        w_mb  = r_pi[0] ? w_fc  : w_fb;
        w_mul = w_ma * w_mb;
    end

    // term sum, rounding and saturation for one part
    logic signed [CW:0]   w_sum, w_rnd;
    logic signed [15:0]   w_sat;
    always_comb begin
        unique case (r_qi)
            2'd0: w_sum = {r_prod[0][CW-1], r_prod[0]} + {r_prod[1][CW-1], r_prod[1]};
            2'd1: w_sum = {r_prod[2][CW-1], r_prod[2]} - {r_prod[3][CW-1], r_prod[3]};
            2'd2: w_sum = {r_prod[4][CW-1], r_prod[4]} + {r_prod[5][CW-1], r_prod[5]};
            default: w_sum = {r_prod[6][CW-1], r_prod[6]} - {r_prod[7][CW-1], r_prod[7]};
        endcase
        w_rnd = (w_sum + (CW+1)'(1 << (SH - 1))) >>> SH;
        if (w_rnd > (CW+1)'(ONE_Q))       w_sat = 16'sd16384;
        else if (w_rnd < -(CW+1)'(ONE_Q)) w_sat = -16'sd16384;
        else                              w_sat = w_rnd[15:0];
    end

    logic signed [31:0] w_dp;
    assign w_dp = r_q[r_qi] * r_prev[r_qi];

    always_comb begin
        n_state = r_state; n_ai = r_ai; n_cwait = r_cwait; n_pi = r_pi; n_qi = r_qi;
        n_ov = r_ov;
        w_cstart = 1'b0;
        w_cang = r_ang[r_ai];
        unique case (r_state)
            e2q_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = e2q_pkg::ST_CORDIC; n_ai = '0; n_cwait = 1'b0;
                end
            end
            e2q_pkg::ST_CORDIC: begin
                // capture cycle: move on to the next angle or to the products
                if (r_clatch) begin
                    n_cwait = 1'b0;
                    if (r_ai == 2'd2) begin
                        n_state = e2q_pkg::ST_PROD; n_pi = '0;
                    end else begin
                        n_ai = r_ai + 1'b1;
                    end
                end else if (!r_cwait) begin
                    w_cstart = 1'b1; n_cwait = 1'b1;
                end
            end
            e2q_pkg::ST_PROD: begin
                n_pi = r_pi + 1'b1;
                if (r_pi == 4'd15) begin
                    n_state = e2q_pkg::ST_SUM; n_qi = '0;
                end
            end
            e2q_pkg::ST_SUM: begin
                n_qi = r_qi + 1'b1;
                if (r_qi == 2'd3) n_state = e2q_pkg::ST_DOT;
            end
            e2q_pkg::ST_DOT: begin
                n_qi = r_qi + 1'b1;
                if (r_qi == 2'd3) n_state = e2q_pkg::ST_OUT;
            end
            e2q_pkg::ST_OUT: begin
                n_ov = 1'b1;
                if (r_ov && i_ready) begin
                    n_ov = 1'b0; n_state = e2q_pkg::ST_IDLE;
                end
            end
            default: n_state = e2q_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= e2q_pkg::ST_IDLE;
            r_ai     <= '0;
            r_cwait  <= 1'b0;
            r_pi     <= '0;
            r_qi     <= '0;
            r_ov     <= 1'b0;
            r_clatch <= 1'b0;
            r_prev[0] <= 16'sd16384;
            r_prev[1] <= '0;
            r_prev[2] <= '0;
            r_prev[3] <= '0;
        end else begin
            r_state  <= n_state;
            r_ai     <= n_ai;
            r_cwait  <= n_cwait;
            r_pi     <= n_pi;
            r_qi     <= n_qi;
            r_ov     <= n_ov;
            r_clatch <= w_cdone;
            if (r_state == e2q_pkg::ST_OUT && !r_ov) begin
                for (int k = 0; k < 4; k++)
                    r_prev[k] <= r_dot[36] ? -r_q[k] : r_q[k];
            end
        end
        if (r_state == e2q_pkg::ST_IDLE && i_valid) begin
            // half angle in q30: shift left by 32-16
            r_ang[0] <= CW'(i_data.yaw_angle)   <<< 16;
            r_ang[1] <= CW'(i_data.pitch_angle) <<< 16;
            r_ang[2] <= CW'(i_data.roll_angle)  <<< 16;
        end
        if (r_clatch) begin
            r_sn[r_ai] <= w_sin;
        end
        if (r_state == e2q_pkg::ST_PROD) begin
            if (!r_pi[0]) r_tmp <= CW'(w_mul >>> e2q_pkg::FRAC_BITS);
            else          r_prod[r_pi[3:1]] <= CW'(w_mul >>> e2q_pkg::FRAC_BITS);
        end
        if (r_state == e2q_pkg::ST_SUM) begin
            r_q[r_qi] <= w_sat;
            r_dot     <= '0;
        end
        if (r_state == e2q_pkg::ST_DOT)
            r_dot <= r_dot + 37'(w_dp);
        if (r_state == e2q_pkg::ST_OUT && !r_ov) begin
            r_out.quat_w <= r_dot[36] ? -r_q[0] : r_q[0];
            r_out.quat_x <= r_dot[36] ? -r_q[1] : r_q[1];
            r_out.quat_y <= r_dot[36] ? -r_q[2] : r_q[2];
            r_out.quat_z <= r_dot[36] ? -r_q[3] : r_q[3];
        end
    end

    // cos capture follows the same index as sin
    always_ff @(posedge i_clk) begin
        if (r_clatch)
            r_cs[r_ai] <= w_cos;
    end

    assign o_ready = (r_state == e2q_pkg::ST_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_out_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == e2q_pkg::ST_OUT)
        else $error("output valid outside output state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != e2q_pkg::ST_IDLE) |-> !o_ready)
        else $error("ready while busy");
    a_done_only_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cdone |-> r_state == e2q_pkg::ST_CORDIC)
        else $error("cordic finished outside cordic phase");
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid && o_ready)
        else $error("output not released");
endmodule
